@@ rtl/odo_pkg.sv @@
// Shared types, constants and helper functions for the differential drive odometry block.
package odo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ARC_IDX_W        = 5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int SPEED_W = 16;
    localparam int TIME_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;

    localparam int VEC_W   = 34;
    localparam int ANG_W   = 33;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = 60;
    localparam int DIST_W  = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN = 2'd1;

    localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST   = 16'd1180;
    localparam logic [GAIN_W-1:0] HEADING_GAIN_RST = 16'd23114;
    localparam logic [HEAD_W-1:0] HEADING_RST      = 16'd49152;

    localparam logic signed [VEC_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [VEC_W-1:0] POS_MAX  = 34'sd2147483647;
    localparam logic signed [VEC_W-1:0] POS_MIN  = -34'sd2147483648;

    typedef struct packed {
        logic                    done;
        logic signed [VEC_W-1:0] sin_val;
        logic signed [VEC_W-1:0] cos_val;
    } cordic_res_t;

    // Rotation angle of each CORDIC step in units of 2^-32 turn.
    function automatic logic signed [ANG_W-1:0] arc_angle(input logic [ARC_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            5'd0:    r = 33'sd536870912;
            5'd1:    r = 33'sd316933406;
            5'd2:    r = 33'sd167458907;
            5'd3:    r = 33'sd85004756;
            5'd4:    r = 33'sd42667331;
            5'd5:    r = 33'sd21354465;
            5'd6:    r = 33'sd10679838;
            5'd7:    r = 33'sd5340245;
            5'd8:    r = 33'sd2670163;
            5'd9:    r = 33'sd1335087;
            5'd10:   r = 33'sd667544;
            5'd11:   r = 33'sd333772;
            5'd12:   r = 33'sd166886;
            5'd13:   r = 33'sd83443;
            5'd14:   r = 33'sd41722;
            5'd15:   r = 33'sd20861;
            5'd16:   r = 33'sd10430;
            5'd17:   r = 33'sd5215;
            5'd18:   r = 33'sd2608;
            5'd19:   r = 33'sd1304;
            5'd20:   r = 33'sd652;
            5'd21:   r = 33'sd326;
            5'd22:   r = 33'sd163;
            5'd23:   r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VEC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX[POS_W-1:0];
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/odo_mult.sv @@
// Shared signed multiplier with a registered product.
module odo_mult
    import odo_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ rtl/odo_cordic.sv @@
// Iterative CORDIC in rotation mode giving sine and cosine of a binary angle.
module odo_cordic
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HEAD_W-1:0] angle,
    output cordic_res_t       res
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    flip_reg, flip_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;

    logic signed [HEAD_W-1:0] angle_s;
    logic                     flip_in;
    logic [HEAD_W-1:0]        angle_adj;
    logic signed [VEC_W-1:0]  x_sh, y_sh;
    logic signed [ANG_W-1:0]  arc;

    always_comb
    begin
        angle_s   = angle;
        flip_in   = (angle_s > 16'sd16384) || (angle_s < -16'sd16384);
        angle_adj = flip_in ? {~angle[HEAD_W-1], angle[HEAD_W-2:0]} : angle;
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;
        arc       = arc_angle(ARC_IDX_W'(cnt_reg));

        busy_next = busy_reg;
        done_next = done_reg;
        flip_next = flip_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            flip_next = flip_in;
            cnt_next  = '0;
            x_next    = CORDIC_K;
            y_next    = '0;
            z_next    = {angle_adj[HEAD_W-1], angle_adj, 16'b0};
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - arc;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + arc;
            end
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    always_comb
    begin
        res.done    = done_reg;
        res.sin_val = flip_reg ? -y_reg : y_reg;
        res.cos_val = flip_reg ? -x_reg : x_reg;
    end

endmodule

@@ rtl/diff_drive_odometry.sv @@
// Top level of the differential drive odometry block: sequencer, pose state and ports.
//
// One request carries left_speed, right_speed and elapsed on a valid/ready channel.
// The block takes a request only while it is idle; it then runs the distance and
// turn products through one shared multiplier while a CORDIC unit rotates the old
// heading, one iteration per cycle. The sequencer then waits for the CORDIC result,
// forms the position update through the same multiplier and loads the new pose into
// the output register behind pos_x, pos_y and heading_out. Only then does it return
// to idle, so it cannot take a new request before it is through with the last one.
// The result sits in an output register and the block takes the next request while
// it waits. If the previous result has still not been taken when a new one is ready,
// the sequencer holds in its last step until the receiver takes it.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and must
// only be made while the block is idle. Reset clears the position to zero, sets the
// heading to minus a quarter turn and loads the default gains.
module diff_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SPEED_W-1:0]  left_speed,
    input  logic signed [SPEED_W-1:0]  right_speed,
    input  logic [TIME_W-1:0]          elapsed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [POS_W-1:0]    pos_x,
    output logic signed [POS_W-1:0]    pos_y,
    output logic [HEAD_W-1:0]          heading_out
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_M1   = 10'b0000000010,
        S_M2   = 10'b0000000100,
        S_M3   = 10'b0000001000,
        S_M4   = 10'b0000010000,
        S_M5   = 10'b0000100000,
        S_WAIT = 10'b0001000000,
        S_MS   = 10'b0010000000,
        S_MC   = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    localparam logic signed [MUL_P_W-1:0] RND23 = 60'sd1 <<< 23;
    localparam logic signed [MUL_P_W-1:0] RND27 = 60'sd1 <<< 27;
    localparam logic signed [MUL_P_W-1:0] RND29 = 60'sd1 <<< 29;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]          drive_gain_reg, drive_gain_next;
    logic [GAIN_W-1:0]          heading_gain_reg, heading_gain_next;
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [HEAD_W-1:0]          heading_reg, heading_next;

    logic signed [SPEED_W-1:0]  left_reg, left_next;
    logic signed [SPEED_W-1:0]  right_reg, right_next;
    logic [TIME_W-1:0]          dt_reg, dt_next;
    logic signed [DIST_W-1:0]   dist_reg, dist_next;
    logic [HEAD_W-1:0]          turn_reg, turn_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]    out_x_reg, out_x_next;
    logic signed [POS_W-1:0]    out_y_reg, out_y_next;
    logic [HEAD_W-1:0]          out_h_reg, out_h_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    logic                       cordic_start;
    cordic_res_t                cordic_res;

    logic                       accept;
    logic                       load_ok;
    logic signed [SPEED_W:0]    wheel_sum;
    logic signed [SPEED_W:0]    wheel_diff;
    logic signed [MUL_P_W-1:0]  p_rnd24, p_rnd28, p_rnd30;
    logic signed [VEC_W-1:0]    x_sum, y_sum;
    logic signed [MUL_B_W-1:0]  dist_ext;

    odo_mult u_mult
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (heading_reg),
        .res   (cordic_res)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign cordic_start = accept;
    assign load_ok      = !out_valid_reg || out_ready;

    always_comb
    begin
        wheel_sum  = {left_reg[SPEED_W-1], left_reg} + {right_reg[SPEED_W-1], right_reg};
        wheel_diff = {right_reg[SPEED_W-1], right_reg} - {left_reg[SPEED_W-1], left_reg};
        p_rnd24    = (mul_p + RND23) >>> 24;
        p_rnd28    = (mul_p + RND27) >>> 28;
        p_rnd30    = (mul_p + RND29) >>> 30;
        dist_ext   = {{(MUL_B_W-DIST_W){dist_reg[DIST_W-1]}}, dist_reg};
        x_sum      = {{(VEC_W-POS_W){pos_x_reg[POS_W-1]}}, pos_x_reg} - p_rnd30[VEC_W-1:0];
        y_sum      = {{(VEC_W-POS_W){pos_y_reg[POS_W-1]}}, pos_y_reg} + p_rnd30[VEC_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        drive_gain_next   = drive_gain_reg;
        heading_gain_next = heading_gain_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        heading_next      = heading_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        dt_next           = dt_reg;
        dist_next         = dist_reg;
        turn_next         = turn_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_h_next        = out_h_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mul_a             = '0;
        mul_b             = '0;

        if (cfg_we)
        begin
            if (cfg_index == REG_DRIVE_GAIN)
            begin
                drive_gain_next = cfg_data;
            end
            else if (cfg_index == REG_HEADING_GAIN)
            begin
                heading_gain_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    left_next  = left_speed;
                    right_next = right_speed;
                    dt_next    = elapsed;
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                mul_a      = {{(MUL_A_W-SPEED_W-1){wheel_sum[SPEED_W]}}, wheel_sum};
                mul_b      = {{(MUL_B_W-GAIN_W){1'b0}}, drive_gain_reg};
                state_next = S_M2;
            end
            S_M2:
            begin
                mul_a      = mul_p[MUL_A_W-1:0];
                mul_b      = {{(MUL_B_W-TIME_W){1'b0}}, dt_reg};
                state_next = S_M3;
            end
            S_M3:
            begin
                dist_next  = p_rnd24[DIST_W-1:0];
                mul_a      = {{(MUL_A_W-SPEED_W-1){wheel_diff[SPEED_W]}}, wheel_diff};
                mul_b      = {{(MUL_B_W-TIME_W){1'b0}}, dt_reg};
                state_next = S_M4;
            end
            S_M4:
            begin
                mul_a      = mul_p[MUL_A_W-1:0];
                mul_b      = {{(MUL_B_W-GAIN_W){1'b0}}, heading_gain_reg};
                state_next = S_M5;
            end
            S_M5:
            begin
                turn_next  = p_rnd28[HEAD_W-1:0];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (cordic_res.done)
                begin
                    state_next = S_MS;
                end
            end
            S_MS:
            begin
                mul_a      = cordic_res.sin_val;
                mul_b      = dist_ext;
                state_next = S_MC;
            end
            S_MC:
            begin
                pos_x_next = sat_pos(x_sum);
                mul_a      = cordic_res.cos_val;
                mul_b      = dist_ext;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                mul_a = cordic_res.cos_val;
                mul_b = dist_ext;
                if (load_ok)
                begin
                    pos_y_next     = sat_pos(y_sum);
                    heading_next   = heading_reg + turn_reg;
                    out_x_next     = pos_x_reg;
                    out_y_next     = sat_pos(y_sum);
                    out_h_next     = heading_reg + turn_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            drive_gain_reg   <= DRIVE_GAIN_RST;
            heading_gain_reg <= HEADING_GAIN_RST;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            heading_reg      <= HEADING_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            drive_gain_reg   <= drive_gain_next;
            heading_gain_reg <= heading_gain_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            heading_reg      <= heading_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        dt_reg    <= dt_next;
        dist_reg  <= dist_next;
        turn_reg  <= turn_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign heading_out = out_h_reg;

endmodule

@@ rtl/odo_checker.sv @@
// Port-level assertions for the odometry block and the bind that attaches them.
module odo_checker
    import odo_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] pos_x,
    input logic signed [POS_W-1:0] pos_y,
    input logic [HEAD_W-1:0]       heading_out
);

    // The block stays busy, with in_ready low, after taking a request.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready ##1 !in_ready))
        else $error("block took a request while still busy");

    // A new result is only loaded while the block is busy with a request.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in progress");

    // A result never appears in the cycle right after a request is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // A stalled result holds its pose.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading_out)))
        else $error("stalled result changed");

endmodule

bind diff_drive_odometry odo_checker u_odo_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading_out (heading_out)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the differential drive odometry block.
module testbench
    import odo_pkg::*;
;
    localparam int ROTATIONS   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RESULT_WAIT = ROTATIONS + 24;
    localparam longint VEC_START = 652032874;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic [TIME_W-1:0]         dt;
    } request_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [HEAD_W-1:0]       angle;
    } pose_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [SPEED_W-1:0] left_speed = '0;
    logic signed [SPEED_W-1:0] right_speed = '0;
    logic [TIME_W-1:0]         elapsed = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [HEAD_W-1:0]         heading_out;

    // Rotation angle of each CORDIC step in units of 2^-32 turn.
    longint arc_turn [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Pose and gains as the block should hold them.
    logic [GAIN_W-1:0] gain_drive = DRIVE_GAIN_RST;
    logic [GAIN_W-1:0] gain_turn = HEADING_GAIN_RST;
    longint            est_x = 0;
    longint            est_y = 0;
    logic [HEAD_W-1:0] est_heading = HEADING_RST;

    request_t request_q [$];
    pose_t    pose_q [$];
    request_t staged;
    pose_t    want;
    int       requests_open = 0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       cycles = 0;
    bit       calm = 1'b0;

    diff_drive_odometry #(
        .CORDIC_STEPS(ROTATIONS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .left_speed(left_speed),
        .right_speed(right_speed),
        .elapsed(elapsed),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .heading_out(heading_out)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_q16(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Sine and cosine of a binary angle in Q2.30; angles past a quarter turn are
    // turned by half a turn first and the results negated.
    function automatic void heading_sin_cos(input logic [HEAD_W-1:0] ang,
                                           output longint s, output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        int     i;
        a = longint'($signed(ang));
        flip = (a > 16384) || (a < -16384);
        if (flip)
        begin
            a = longint'($signed(ang ^ 16'h8000));
        end
        x = VEC_START;
        y = 0;
        z = a * 65536;
        for (i = 0; i < ROTATIONS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arc_turn[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arc_turn[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Moves the tracked pose by one request and returns the pose the block should emit.
    function automatic pose_t advance_pose(input logic signed [SPEED_W-1:0] l,
                                           input logic signed [SPEED_W-1:0] r,
                                           input logic [TIME_W-1:0] dt);
        longint travel;
        longint turn;
        longint s;
        longint c;
        pose_t  p;
        travel = longint'(gain_drive) * (longint'(l) + longint'(r)) * longint'(dt);
        travel = (travel + (longint'(1) <<< 23)) >>> 24;
        heading_sin_cos(est_heading, s, c);
        est_x = clamp_q16(est_x - ((travel * s + (longint'(1) <<< 29)) >>> 30));
        est_y = clamp_q16(est_y + ((travel * c + (longint'(1) <<< 29)) >>> 30));
        turn = (longint'(r) - longint'(l)) * longint'(dt) * longint'(gain_turn);
        turn = (turn + (longint'(1) <<< 27)) >>> 28;
        est_heading = est_heading + 16'(turn);
        p.x = est_x[POS_W-1:0];
        p.y = est_y[POS_W-1:0];
        p.angle = est_heading;
        return p;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_length();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (calm)
        begin
            n = 0;
        end
        else if (r < 50)
        begin
            n = 0;
        end
        else if (r < 85)
        begin
            n = $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            n = $urandom_range(4, 15);
        end
        else
        begin
            n = $urandom_range(20, 80);
        end
        return n;
    endfunction

    function automatic logic signed [SPEED_W-1:0] extreme_speed();
        logic signed [SPEED_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = 16'sh8000;
            1:       v = -16'sd1;
            2:       v = 16'sd0;
            3:       v = 16'sd1;
            default: v = 16'sh7FFF;
        endcase
        return v;
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_speed();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return extreme_speed();
        end
        else if (r < 5)
        begin
            v = int'($urandom_range(0, 5120)) - 2560;
            return 16'(v);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] random_elapsed();
        int r;
        logic [TIME_W-1:0] v;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            v = '0;
        end
        else if (r == 1)
        begin
            v = '1;
        end
        else if (r < 10)
        begin
            v = 16'($urandom_range(1, 4096));
        end
        else
        begin
            v = 16'($urandom);
        end
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] dflt);
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = '1;
            2:       g = dflt;
            default: g = 16'($urandom);
        endcase
        return g;
    endfunction

    task automatic send(input int l, input int r, input int dt);
        request_t q;
        q.left = 16'(l);
        q.right = 16'(r);
        q.dt = 16'(dt);
        request_q.push_back(q);
        requests_open++;
    endtask

    task automatic wait_drained();
        while (requests_open != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Written only while the block is idle, so the tracked gains change at the same edge.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DRIVE_GAIN)
        begin
            gain_drive = value;
        end
        else if (idx == REG_HEADING_GAIN)
        begin
            gain_turn = value;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pose_q.push_back(advance_pose(left_speed, right_speed, elapsed));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    staged = request_q.pop_front();
                    left_speed <= staged.left;
                    right_speed <= staged.right;
                    elapsed <= staged.dt;
                    in_valid <= 1'b1;
                    send_gap = idle_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pose_q.size() == 0)
                begin
                    $error("Result with no request outstanding: pos_x %0d pos_y %0d heading %0d",
                           pos_x, pos_y, heading_out);
                    mismatches++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    requests_open--;
                    if (pos_x !== want.x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.x, pos_x);
                        mismatches++;
                    end
                    if (pos_y !== want.y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.y, pos_y);
                        mismatches++;
                    end
                    if (heading_out !== want.angle)
                    begin
                        $error("heading_out: expected %0d, got %0d", want.angle, heading_out);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = idle_length();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        int mag;
        int dir;
        int l;
        int r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Default gains: standing still, full speed and full turns both ways, mixed cases.
        send(0, 0, 0);
        send(256, 256, 3277);
        send(32767, 32767, 65535);
        send(-32768, -32768, 65535);
        send(-32768, 32767, 65535);
        send(32767, -32768, 65535);
        send(1000, -1000, 0);
        send(-1, 1, 1);
        send(0, 0, 65535);
        send(12345, -4321, 40000);
        wait_drained();

        // Writes to the unused indexes must leave both gains alone.
        write_register(REG_SPARE_LO, 16'hFFFF);
        write_register(REG_SPARE_HI, 16'h0000);
        send(32767, 32767, 65535);
        wait_drained();

        write_register(REG_DRIVE_GAIN, 16'hFFFF);
        write_register(REG_HEADING_GAIN, 16'hFFFF);
        send(32767, 32767, 65535);
        send(-32768, -32768, 65535);
        send(-32768, 32767, 65535);
        send(32767, -32768, 65535);
        send(1, 0, 1);
        send(0, 0, 0);
        wait_drained();

        write_register(REG_DRIVE_GAIN, 16'h0000);
        write_register(REG_HEADING_GAIN, 16'h0000);
        send(32767, -32768, 65535);
        send(-32768, -32768, 65535);
        send(0, 0, 0);
        wait_drained();

        // Long straight run at full gain drives the position into saturation, then back out.
        write_register(REG_DRIVE_GAIN, 16'hFFFF);
        write_register(REG_HEADING_GAIN, 16'h0000);
        dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
        for (n = 0; n < 240; n++)
        begin
            if (n == 200)
            begin
                dir = -dir;
            end
            mag = $urandom_range(28000, 32767);
            l = dir * mag;
            mag = $urandom_range(28000, 32767);
            r = dir * mag;
            send(l, r, $urandom_range(60000, 65535));
        end
        wait_drained();

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                calm = 1'b1;
                write_register(REG_DRIVE_GAIN, DRIVE_GAIN_RST);
                write_register(REG_HEADING_GAIN, HEADING_GAIN_RST);
            end
            else
            begin
                calm = ($urandom_range(0, 3) == 0);
                write_register(REG_DRIVE_GAIN, pick_gain(DRIVE_GAIN_RST));
                write_register(REG_HEADING_GAIN, pick_gain(HEADING_GAIN_RST));
            end
            for (n = 0; n < 130; n++)
            begin
                send(random_speed(), random_speed(), random_elapsed());
            end
            wait_drained();
        end

        repeat (RESULT_WAIT) @(posedge clk);
        if (pose_q.size() != 0)
        begin
            $error("%0d expected poses never arrived", pose_q.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
